FILE: hdl/vra_pkg.sv
// ----------------------------------------------------------------------------
// vra_pkg
// Shared types, constants, latencies and rounding helpers for the vector
// alignment rotation pipeline.
// ----------------------------------------------------------------------------
package vra_pkg;

  // Input coordinates are taken as the low COORD_WIDTH bits of each field.
  // The fields are 32 bits wide, so this is fixed at 32.
  localparam int COORD_WIDTH = 32;

  // Pipeline depths
  localparam int SQRT_LAT  = 32;                        // one root bit per stage
  localparam int DIV_STEPS = 31;                        // one quotient bit per stage
  localparam int NORM_LAT  = 4 + SQRT_LAT + 1 + DIV_STEPS + 1;
  localparam int MAT_LAT   = 4;
  localparam int PIPE_LAT  = NORM_LAT + 2 + NORM_LAT + MAT_LAT;
  localparam int C_DLY     = NORM_LAT - 1;              // cosine to matrix input
  localparam int S_DLY     = NORM_LAT - 3 - SQRT_LAT;   // sine root to matrix input

  localparam logic signed [31:0] ONE_Q30   = 32'sh4000_0000;
  localparam logic        [9:0]  THR_RESET = 10'd11;

  typedef logic signed [31:0] q30_t;
  typedef logic signed [63:0] s64_t;
  typedef logic signed [71:0] s72_t;

  typedef enum logic [1:0] {
    CODE_IDENT = 2'd0,
    CODE_NEG   = 2'd1,
    CODE_HALF  = 2'd2,
    CODE_ROD   = 2'd3
  } case_code_t;

  // Register index (byte address bit 2)
  typedef enum logic [0:0] {
    REG_THR = 1'b0
  } reg_idx_t;

  // Shift right by 30, round to nearest, ties away from zero
  function automatic s72_t rnd30(input s72_t x);
    logic [71:0] m;
    logic [71:0] r;
    m = x[71] ? 72'(-x) : 72'(x);
    r = (m + (72'd1 << 29)) >> 30;
    return x[71] ? -$signed(r) : $signed(r);
  endfunction

  // Clamp to the signed 32-bit range
  function automatic q30_t sat32(input s72_t x);
    if (x > 72'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    else if (x < -72'sh8000_0000) return 32'sh8000_0000;
    else return x[31:0];
  endfunction

endpackage

FILE: hdl/vra_isqrt.sv
// ----------------------------------------------------------------------------
// vra_isqrt
// Pipelined integer square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module vra_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] v_in,
  output logic [31:0] root
);

  logic [63:0] v_r [vra_pkg::SQRT_LAT];
  logic [63:0] q_r [vra_pkg::SQRT_LAT];

  for (genvar k = 0; k < vra_pkg::SQRT_LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] v_cur;
    logic [63:0] q_cur;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign v_cur = v_in;
      assign q_cur = '0;
    end else begin : g_next
      assign v_cur = v_r[k-1];
      assign q_cur = q_r[k-1];
    end

    assign trial = q_cur + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (v_cur >= trial) begin
          v_r[k] <= v_cur - trial;
          q_r[k] <= (q_cur >> 1) + BIT;
        end else begin
          v_r[k] <= v_cur;
          q_r[k] <= q_cur >> 1;
        end
      end
    end
  end

  assign root = q_r[vra_pkg::SQRT_LAT-1][31:0];

endmodule

FILE: hdl/vra_norm3.sv
// ----------------------------------------------------------------------------
// vra_norm3
// Pipelined 3-vector normalizer: prescale, sum of squares, root, then one
// restoring divide per component. Output is Q2.30; zero in gives zero out.
// ----------------------------------------------------------------------------
module vra_norm3 (
  input  logic                clk,
  input  logic                en,
  input  vra_pkg::s64_t       vin  [3],
  output vra_pkg::q30_t       uout [3]
);

  typedef struct packed {
    logic [2:0][29:0] sh;
    logic [2:0]       neg;
    logic             zero;
  } side_t;

  // stage 1: magnitudes and max
  logic [63:0] mag_nxt [3];
  logic [63:0] max_nxt;
  logic [63:0] mag_r   [3];
  logic [2:0]  neg1_r;
  logic [63:0] max_r;

  always_comb begin
    max_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      mag_nxt[i] = vin[i][63] ? 64'(-vin[i]) : 64'(vin[i]);
      if (mag_nxt[i] > max_nxt) max_nxt = mag_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag_r[i]  <= mag_nxt[i];
        neg1_r[i] <= vin[i][63];
      end
      max_r <= max_nxt;
    end
  end

  // stage 2: bring the largest magnitude into [2^29, 2^30)
  logic [6:0]  len;
  logic [63:0] shv [3];
  side_t       side2_nxt;
  side_t       side2_r;

  always_comb begin
    len = '0;
    for (int b = 0; b < 64; b++) begin
      if (max_r[b]) len = 7'(b + 1);
    end
    side2_nxt.neg  = neg1_r;
    side2_nxt.zero = (max_r == '0);
    for (int i = 0; i < 3; i++) begin
      if (len > 7'd30) shv[i] = mag_r[i] >> (len - 7'd30);
      else             shv[i] = mag_r[i] << (7'd30 - len);
      side2_nxt.sh[i] = shv[i][29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) side2_r <= side2_nxt;
  end

  // stage 3: squares
  logic [59:0] sq_r [3];
  side_t       side3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq_r[i] <= 60'(side2_r.sh[i]) * 60'(side2_r.sh[i]);
      end
      side3_r <= side2_r;
    end
  end

  // stage 4: sum of squares
  logic [61:0] sum_r;
  side_t       side4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r   <= 62'(sq_r[0]) + 62'(sq_r[1]) + 62'(sq_r[2]);
      side4_r <= side3_r;
    end
  end

  // root, with the side data delayed alongside
  logic [31:0] root;
  side_t       sdl_r [vra_pkg::SQRT_LAT];

  vra_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .v_in ({2'b00, sum_r}),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sdl_r[0] <= side4_r;
      for (int k = 1; k < vra_pkg::SQRT_LAT; k++) sdl_r[k] <= sdl_r[k-1];
    end
  end

  // divide setup: numerator = a*2^30 + n/2
  side_t       sd0;
  logic [60:0] num_r [3];
  logic [30:0] dn_r;
  side_t       side5_r;

  assign sd0 = sdl_r[vra_pkg::SQRT_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        num_r[i] <= {1'b0, sd0.sh[i], 30'b0} + 61'(root[31:1]);
      end
      dn_r    <= root[30:0];
      side5_r <= sd0;
    end
  end

  // restoring divide, one quotient bit per stage
  logic [30:0] rem_r [3][vra_pkg::DIV_STEPS];
  logic [30:0] quo_r [3][vra_pkg::DIV_STEPS];
  logic [60:0] nm_r  [3][vra_pkg::DIV_STEPS];
  logic [30:0] dv_r  [vra_pkg::DIV_STEPS];
  side_t       ds_r  [vra_pkg::DIV_STEPS];

  for (genvar j = 0; j < vra_pkg::DIV_STEPS; j++) begin : g_div
    localparam int B = vra_pkg::DIV_STEPS - 1 - j;
    logic [30:0] rem_in [3];
    logic [30:0] quo_in [3];
    logic [60:0] nm_in  [3];
    logic [30:0] dv_in;
    side_t       ds_in;
    logic [31:0] trial  [3];

    if (j == 0) begin : g_first
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign rem_in[i] = {1'b0, num_r[i][60:31]};
        assign quo_in[i] = '0;
        assign nm_in[i]  = num_r[i];
      end
      assign dv_in = dn_r;
      assign ds_in = side5_r;
    end else begin : g_next
      for (genvar i = 0; i < 3; i++) begin : g_c
        assign rem_in[i] = rem_r[i][j-1];
        assign quo_in[i] = quo_r[i][j-1];
        assign nm_in[i]  = nm_r[i][j-1];
      end
      assign dv_in = dv_r[j-1];
      assign ds_in = ds_r[j-1];
    end

    for (genvar i = 0; i < 3; i++) begin : g_t
      assign trial[i] = {rem_in[i], nm_in[i][B]};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int i = 0; i < 3; i++) begin
          if (trial[i] >= {1'b0, dv_in}) begin
            rem_r[i][j] <= 31'(trial[i] - {1'b0, dv_in});
            quo_r[i][j] <= {quo_in[i][29:0], 1'b1};
          end else begin
            rem_r[i][j] <= trial[i][30:0];
            quo_r[i][j] <= {quo_in[i][29:0], 1'b0};
          end
          nm_r[i][j] <= nm_in[i];
        end
        dv_r[j] <= dv_in;
        ds_r[j] <= ds_in;
      end
    end
  end

  // sign and zero
  side_t         sdf;
  vra_pkg::q30_t u_r [3];

  assign sdf = ds_r[vra_pkg::DIV_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        if (sdf.zero)       u_r[i] <= '0;
        else if (sdf.neg[i]) u_r[i] <= -$signed({1'b0, quo_r[i][vra_pkg::DIV_STEPS-1]});
        else                u_r[i] <= $signed({1'b0, quo_r[i][vra_pkg::DIV_STEPS-1]});
      end
    end
  end

  assign uout = u_r;

endmodule

FILE: hdl/vra_matrix.sv
// ----------------------------------------------------------------------------
// vra_matrix
// Case selection and matrix assembly from cosine, unit axis and sine.
// Four register stages.
// ----------------------------------------------------------------------------
module vra_matrix (
  input  logic                clk,
  input  logic                en,
  input  vra_pkg::q30_t       cos_in,
  input  vra_pkg::q30_t       k    [3],
  input  logic [31:0]         sin_in,
  input  logic [9:0]          thr,
  output vra_pkg::q30_t       m    [9],
  output vra_pkg::case_code_t code
);

  // symmetric product slot per entry: diagonals 0..2, then 01, 02, 12
  localparam int SYM_IDX [9] = '{0, 3, 4, 3, 1, 5, 4, 5, 2};
  // sine term per entry: which axis component, present, negated
  localparam int           SU_IDX [9] = '{0, 2, 1, 2, 0, 0, 1, 0, 0};
  localparam logic [8:0]   SU_ON  = 9'b011_101_110;
  localparam logic [8:0]   SU_NEG = 9'b001_100_010;
  localparam logic [8:0]   DIAG   = 9'b100_010_001;

  // stage 1: tests and products
  logic signed [33:0]  d1;
  logic signed [33:0]  d2;
  logic [33:0]         ad1;
  logic [33:0]         ad2;
  vra_pkg::case_code_t code_nxt;
  logic signed [63:0]  kk_r [6];
  logic signed [65:0]  sk_r [3];
  logic signed [33:0]  omc1_r;
  vra_pkg::case_code_t code1_r;

  always_comb begin
    d1  = 34'sh4000_0000 - 34'(cos_in);
    d2  = -34'sh4000_0000 - 34'(cos_in);
    ad1 = d1[33] ? 34'(-d1) : 34'(d1);
    ad2 = d2[33] ? 34'(-d2) : 34'(d2);
    if (ad1 < 34'(thr))                          code_nxt = vra_pkg::CODE_IDENT;
    else if (k[0] == '0 && k[1] == '0 && k[2] == '0) code_nxt = vra_pkg::CODE_NEG;
    else if (ad2 < 34'(thr))                     code_nxt = vra_pkg::CODE_HALF;
    else                                          code_nxt = vra_pkg::CODE_ROD;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kk_r[0] <= 64'(k[0]) * 64'(k[0]);
      kk_r[1] <= 64'(k[1]) * 64'(k[1]);
      kk_r[2] <= 64'(k[2]) * 64'(k[2]);
      kk_r[3] <= 64'(k[0]) * 64'(k[1]);
      kk_r[4] <= 64'(k[0]) * 64'(k[2]);
      kk_r[5] <= 64'(k[1]) * 64'(k[2]);
      for (int i = 0; i < 3; i++) begin
        sk_r[i] <= 66'($signed({1'b0, sin_in})) * 66'(k[i]);
      end
      omc1_r  <= d1;
      code1_r <= code_nxt;
    end
  end

  // stage 2: round U*U, 2*k*k^T and s*k to Q2.30
  vra_pkg::s72_t       uu_nxt [6];
  vra_pkg::s72_t       hk_nxt [6];
  vra_pkg::s72_t       su_nxt [3];
  logic signed [33:0]  uu_r   [6];
  logic signed [33:0]  hk_r   [6];
  logic signed [33:0]  su_r   [3];
  logic signed [33:0]  omc2_r;
  vra_pkg::case_code_t code2_r;

  always_comb begin
    uu_nxt[0] = vra_pkg::rnd30(-(72'(kk_r[1]) + 72'(kk_r[2])));
    uu_nxt[1] = vra_pkg::rnd30(-(72'(kk_r[0]) + 72'(kk_r[2])));
    uu_nxt[2] = vra_pkg::rnd30(-(72'(kk_r[0]) + 72'(kk_r[1])));
    for (int i = 3; i < 6; i++) uu_nxt[i] = vra_pkg::rnd30(72'(kk_r[i]));
    for (int i = 0; i < 6; i++) hk_nxt[i] = vra_pkg::rnd30(72'(kk_r[i]) <<< 1);
    for (int i = 0; i < 3; i++) su_nxt[i] = vra_pkg::rnd30(72'(sk_r[i]));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        uu_r[i] <= uu_nxt[i][33:0];
        hk_r[i] <= hk_nxt[i][33:0];
      end
      for (int i = 0; i < 3; i++) su_r[i] <= su_nxt[i][33:0];
      omc2_r  <= omc1_r;
      code2_r <= code1_r;
    end
  end

  // stage 3: (1 - c) * U*U
  logic signed [67:0]  ou_r  [6];
  logic signed [33:0]  hk3_r [6];
  logic signed [33:0]  su3_r [3];
  vra_pkg::case_code_t code3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 6; i++) begin
        ou_r[i]  <= 68'(omc2_r) * 68'(uu_r[i]);
        hk3_r[i] <= hk_r[i];
      end
      su3_r   <= su_r;
      code3_r <= code2_r;
    end
  end

  // stage 4: assemble, clamp, select
  vra_pkg::s72_t       ou_rnd [6];
  vra_pkg::s72_t       acc    [9];
  vra_pkg::q30_t       m_nxt  [9];
  vra_pkg::q30_t       m_r    [9];
  vra_pkg::case_code_t code_r;

  always_comb begin
    for (int i = 0; i < 6; i++) ou_rnd[i] = vra_pkg::rnd30(72'(ou_r[i]));
    for (int e = 0; e < 9; e++) begin
      acc[e]   = '0;
      m_nxt[e] = '0;
      case (code3_r)
        vra_pkg::CODE_IDENT: m_nxt[e] = DIAG[e] ? vra_pkg::ONE_Q30 : '0;
        vra_pkg::CODE_NEG:   m_nxt[e] = DIAG[e] ? -vra_pkg::ONE_Q30 : '0;
        vra_pkg::CODE_HALF: begin
          acc[e] = 72'(hk3_r[SYM_IDX[e]]);
          if (DIAG[e]) acc[e] = acc[e] - 72'(vra_pkg::ONE_Q30);
          m_nxt[e] = vra_pkg::sat32(acc[e]);
        end
        default: begin
          acc[e] = ou_rnd[SYM_IDX[e]];
          if (DIAG[e]) acc[e] = acc[e] + 72'(vra_pkg::ONE_Q30);
          if (SU_ON[e]) begin
            if (SU_NEG[e]) acc[e] = acc[e] - 72'(su3_r[SU_IDX[e]]);
            else           acc[e] = acc[e] + 72'(su3_r[SU_IDX[e]]);
          end
          m_nxt[e] = vra_pkg::sat32(acc[e]);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r    <= m_nxt;
      code_r <= code3_r;
    end
  end

  assign m    = m_r;
  assign code = code_r;

endmodule

FILE: hdl/vector_alignment_rotation_unit.sv
// ----------------------------------------------------------------------------
// vector_alignment_rotation_unit
// Rotation matrix (Q2.30) that turns a start vector onto an end vector.
// ----------------------------------------------------------------------------
// Takes one pair of Q16.16 3-D vectors per clock while the pipeline advances
// and returns the 3x3 matrix rotating the first direction onto the second
// plus a case code (identity, negated identity, half turn, general). The
// depth comes from three normalizers of 69 stages each, two of them side by
// side on the inputs and one on the cross product; each has a 32-stage
// square root and a 31-stage divider working one bit per stage. Throughout
// is one item per cycle. The whole pipeline advances together: it moves
// whenever the output register is empty or being taken, so an idle output
// holds every item in place and nothing is dropped or repeated. The single
// register, parallel_threshold (byte address 0, reset 11), is the Q2.30
// tolerance for treating the cosine as +1 or -1; write it only while idle.
// A zero input vector yields the negated identity.
// ----------------------------------------------------------------------------
module vector_alignment_rotation_unit (
  input  logic         clk,
  input  logic         rst_n,
  // input items
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [191:0] in_tdata,   // start_x, start_y, start_z, end_x, end_y, end_z
  // result items
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  output logic [1:0]   out_tuser,  // case_code
  // configuration
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  localparam int L = vra_pkg::PIPE_LAT;

  // --- configuration -------------------------------------------------------
  logic [9:0]        thr_r;
  vra_pkg::reg_idx_t cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = vra_pkg::reg_idx_t'(cfg_paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= vra_pkg::THR_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      unique case (cfg_idx)
        vra_pkg::REG_THR: thr_r <= cfg_pwdata[9:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vra_pkg::REG_THR: cfg_prdata = {22'b0, thr_r};
      default:          cfg_prdata = '0;
    endcase
  end

  // --- flow control: one global advance ------------------------------------
  logic         adv;
  logic [L-1:0] vld_r;

  assign adv        = !vld_r[L-1] || out_tready;
  assign in_tready  = adv;
  assign out_tvalid = vld_r[L-1];

  always_ff @(posedge clk) begin
    if (!rst_n)   vld_r <= '0;
    else if (adv) vld_r <= {vld_r[L-2:0], in_tvalid};
  end

  // --- normalize both inputs -----------------------------------------------
  vra_pkg::s64_t va [3];
  vra_pkg::s64_t vb [3];
  vra_pkg::q30_t ua [3];
  vra_pkg::q30_t ub [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      va[i] = 64'($signed(in_tdata[32*i +: vra_pkg::COORD_WIDTH]));
      vb[i] = 64'($signed(in_tdata[32*(i+3) +: vra_pkg::COORD_WIDTH]));
    end
  end

  vra_norm3 u_norm_a (.clk(clk), .en(adv), .vin(va), .uout(ua));
  vra_norm3 u_norm_b (.clk(clk), .en(adv), .vin(vb), .uout(ub));

  // --- dot and cross, exact Q4.60 ------------------------------------------
  vra_pkg::s64_t pd_r [3];
  vra_pkg::s64_t pc_r [6];
  vra_pkg::s64_t dot_r;
  vra_pkg::s64_t cr_r [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) pd_r[i] <= 64'(ua[i]) * 64'(ub[i]);
      pc_r[0] <= 64'(ua[1]) * 64'(ub[2]);
      pc_r[1] <= 64'(ua[2]) * 64'(ub[1]);
      pc_r[2] <= 64'(ub[0]) * 64'(ua[2]);
      pc_r[3] <= 64'(ub[2]) * 64'(ua[0]);
      pc_r[4] <= 64'(ua[0]) * 64'(ub[1]);
      pc_r[5] <= 64'(ub[0]) * 64'(ua[1]);
      dot_r   <= pd_r[0] + pd_r[1] + pd_r[2];
      cr_r[0] <= pc_r[0] - pc_r[1];
      cr_r[1] <= pc_r[2] - pc_r[3];
      cr_r[2] <= pc_r[4] - pc_r[5];
    end
  end

  // unit rotation axis
  vra_pkg::q30_t kv [3];

  vra_norm3 u_norm_k (.clk(clk), .en(adv), .vin(cr_r), .uout(kv));

  // --- cosine and sine side path -------------------------------------------
  vra_pkg::s72_t      c_rnd;
  vra_pkg::s72_t      cq_rnd [3];
  vra_pkg::q30_t      c_r;
  logic signed [32:0] cq_r   [3];
  logic [63:0]        csq_r  [3];
  logic [63:0]        ss_r;
  logic [31:0]        s_root;
  vra_pkg::q30_t      c_dl_r [vra_pkg::C_DLY];
  logic [31:0]        s_dl_r [vra_pkg::S_DLY];

  always_comb begin
    c_rnd = vra_pkg::rnd30(72'(dot_r));
    for (int i = 0; i < 3; i++) cq_rnd[i] = vra_pkg::rnd30(72'(cr_r[i]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_r <= c_rnd[31:0];
      for (int i = 0; i < 3; i++) begin
        cq_r[i]  <= cq_rnd[i][32:0];
        csq_r[i] <= 64'(66'(cq_r[i]) * 66'(cq_r[i]));
      end
      ss_r <= csq_r[0] + csq_r[1] + csq_r[2];
      // align cosine and sine with the axis normalizer output
      c_dl_r[0] <= c_r;
      for (int k = 1; k < vra_pkg::C_DLY; k++) c_dl_r[k] <= c_dl_r[k-1];
      s_dl_r[0] <= s_root;
      for (int k = 1; k < vra_pkg::S_DLY; k++) s_dl_r[k] <= s_dl_r[k-1];
    end
  end

  vra_isqrt u_sin (.clk(clk), .en(adv), .v_in(ss_r), .root(s_root));

  // --- matrix assembly ------------------------------------------------------
  vra_pkg::q30_t       mo [9];
  vra_pkg::case_code_t code;

  vra_matrix u_matrix (
    .clk    (clk),
    .en     (adv),
    .cos_in (c_dl_r[vra_pkg::C_DLY-1]),
    .k      (kv),
    .sin_in (s_dl_r[vra_pkg::S_DLY-1]),
    .thr    (thr_r),
    .m      (mo),
    .code   (code)
  );

  always_comb begin
    for (int e = 0; e < 9; e++) out_tdata[32*e +: 32] = mo[e];
  end
  assign out_tuser = code;

  // --- assertions -----------------------------------------------------------
  // identity case carries exactly the identity
  a_ident: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == vra_pkg::CODE_IDENT |->
      out_tdata[31:0] == vra_pkg::ONE_Q30 && out_tdata[63:32] == '0 &&
      out_tdata[159:128] == vra_pkg::ONE_Q30 && out_tdata[287:256] == vra_pkg::ONE_Q30)
    else $error("identity case with wrong matrix");

  // negated identity has zero off-diagonal terms
  a_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == vra_pkg::CODE_NEG |->
      out_tdata[159:128] == -vra_pkg::ONE_Q30 && out_tdata[95:64] == '0 &&
      out_tdata[223:192] == '0)
    else $error("negated identity case with wrong matrix");

  // zero tolerance never selects the near-parallel cases
  a_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && thr_r == '0 |->
      out_tuser != vra_pkg::CODE_IDENT && out_tuser != vra_pkg::CODE_HALF)
    else $error("parallel case taken with zero tolerance");

endmodule

FILE: verif/vector_alignment_rotation_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vector_alignment_rotation_unit_tb
// Self-checking bench for the vector alignment rotation pipeline.
// ----------------------------------------------------------------------------
// A directed set of vector pairs is followed by random ones. The random pairs
// are a mix of general directions, nearly parallel and nearly opposite pairs,
// tiny and zero vectors. The run goes through several tolerance settings,
// zero and full scale among them. Every accepted item is run through a
// fixed-point predictor, and each result is compared field by field with the
// oldest prediction. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module vector_alignment_rotation_unit_tb;

  typedef struct {
    vra_pkg::q30_t       m[9];
    vra_pkg::case_code_t code;
  } rotation_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [191:0] in_tdata;   // start_x, start_y, start_z, end_x, end_y, end_z
  logic         out_tvalid;
  logic         out_tready;
  logic [287:0] out_tdata;  // m00, m01, m02, m10, m11, m12, m20, m21, m22
  logic [1:0]   out_tuser;  // case_code
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  vector_alignment_rotation_unit dut (.*);

  logic [191:0] vec_pairs_q[$];     // items waiting for the driver
  rotation_t    rotations_q[$];     // predicted matrices, oldest first
  logic [9:0]   tol_model;          // predictor's copy of parallel_threshold
  int           mismatches;
  int           items_sent;
  int           results_seen;
  int           code_hist[4];
  int           in_gap;
  int           out_gap;
  int           cycle_cnt;
  int           idle_cycles;

  localparam int WATCHDOG = 20000;

  // ---------------------------------------------------------------- clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ------------------------------------------------------------ predictor
  function automatic longint unsigned magn(longint x);
    return x < 0 ? 64'd0 - 64'(x) : 64'(x);
  endfunction

  // right shift by 30, nearest, ties away from zero
  function automatic longint round30(longint x);
    longint unsigned r;
    r = (magn(x) + (64'd1 << 29)) >> 30;
    return x < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit vector in Q2.30; prescale so the largest magnitude sits at 2^29..2^30
  function automatic void unit_vec(input longint v[3], output longint u[3]);
    longint unsigned a[3];
    longint unsigned top;
    longint unsigned sq;
    longint unsigned n;
    longint unsigned q;
    int len;
    top = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      a[i] = magn(v[i]);
      if (a[i] > top) top = a[i];
    end
    if (top == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return;
    end
    len = 0;
    while (top != 0) begin
      len++;
      top = top >> 1;
    end
    for (int i = 0; i < 3; i++) begin
      if (len > 30) a[i] = a[i] >> (len - 30);
      else if (len < 30) a[i] = a[i] << (30 - len);
      sq += a[i] * a[i];
    end
    n = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = ((a[i] << 30) + (n >> 1)) / n;
      u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic vra_pkg::q30_t clamp32(longint x);
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic rotation_t predict_rotation(logic [191:0] d, logic [9:0] tol);
    rotation_t res;
    longint v1[3], v2[3], a[3], b[3], cr[3], k[3], mt[3][3], sk[3][3], kk[3][3];
    longint c, dd1, dd2, omc, acc, q, idm;
    longint unsigned ss, s;
    for (int i = 0; i < 3; i++) begin
      v1[i] = longint'($signed(d[32*i +: 32]));
      v2[i] = longint'($signed(d[32*(i+3) +: 32]));
    end
    unit_vec(v1, a);
    unit_vec(v2, b);
    c = round30(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    cr[0] = a[1] * b[2] - a[2] * b[1];
    cr[1] = b[0] * a[2] - b[2] * a[0];
    cr[2] = a[0] * b[1] - b[0] * a[1];
    unit_vec(cr, k);
    dd1 = (64'sd1 << 30) - c;
    dd2 = -(64'sd1 << 30) - c;
    if (dd1 < 0) dd1 = -dd1;
    if (dd2 < 0) dd2 = -dd2;
    if (dd1 < longint'(tol)) begin
      res.code = vra_pkg::CODE_IDENT;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) mt[i][j] = (i == j) ? (64'sd1 << 30) : 0;
    end else if (k[0] == 0 && k[1] == 0 && k[2] == 0) begin
      res.code = vra_pkg::CODE_NEG;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) mt[i][j] = (i == j) ? -(64'sd1 << 30) : 0;
    end else if (dd2 < longint'(tol)) begin
      res.code = vra_pkg::CODE_HALF;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          mt[i][j] = round30(2 * k[i] * k[j]) - ((i == j) ? (64'sd1 << 30) : 0);
    end else begin
      res.code = vra_pkg::CODE_ROD;
      ss = 0;
      for (int i = 0; i < 3; i++) begin
        q = round30(cr[i]);
        ss += 64'(q * q);
      end
      s = int_sqrt(ss);
      omc = (64'sd1 << 30) - c;
      sk[0][0] = 0;     sk[0][1] = -k[2]; sk[0][2] = k[1];
      sk[1][0] = k[2];  sk[1][1] = 0;     sk[1][2] = -k[0];
      sk[2][0] = -k[1]; sk[2][1] = k[0];  sk[2][2] = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int t = 0; t < 3; t++) acc += sk[i][t] * sk[t][j];
          kk[i][j] = round30(acc);
        end
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          idm = (i == j) ? (64'sd1 << 30) : 0;
          mt[i][j] = idm + round30(longint'(s) * sk[i][j]) + round30(omc * kk[i][j]);
        end
    end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) res.m[3*i+j] = clamp32(mt[i][j]);
    return res;
  endfunction

  // ------------------------------------------------------------- stimulus
  function automatic logic [191:0] pack_pair(logic [31:0] sx, logic [31:0] sy,
                                             logic [31:0] sz, logic [31:0] ex,
                                             logic [31:0] ey, logic [31:0] ez);
    return {ez, ey, ex, sz, sy, sx};
  endfunction

  function automatic logic [31:0] jitter(logic [31:0] x);
    return x + 32'($signed($urandom_range(0, 6)) - 3);
  endfunction

  // mostly well-formed geometry: parallel, opposite, axis, tiny and zero pairs
  function automatic logic [191:0] random_pair();
    logic [31:0] s[3];
    logic [31:0] e[3];
    int kind;
    int sh;
    kind = $urandom_range(0, 99);
    sh = $urandom_range(0, 8);
    for (int i = 0; i < 3; i++) begin
      s[i] = $urandom;
      e[i] = $urandom;
      if (kind >= 70 && kind < 80) begin
        // tiny components land on exact geometry often
        s[i] = 32'($signed($urandom_range(0, 8)) - 4);
        e[i] = 32'($signed($urandom_range(0, 8)) - 4);
      end
    end
    if (kind >= 35 && kind < 55) begin
      for (int i = 0; i < 3; i++) e[i] = $signed(s[i]) >>> sh;
      if ($urandom_range(0, 1)) e[$urandom_range(0, 2)] = jitter(e[0]);
    end else if (kind >= 55 && kind < 70) begin
      for (int i = 0; i < 3; i++) e[i] = -($signed(s[i]) >>> sh);
      if ($urandom_range(0, 1)) e[$urandom_range(0, 2)] = jitter(e[1]);
    end else if (kind >= 80 && kind < 85) begin
      if ($urandom_range(0, 1)) s = '{0, 0, 0};
      else e = '{0, 0, 0};
    end else if (kind >= 85) begin
      // single-axis vectors, either sign, random scale
      s = '{0, 0, 0};
      e = '{0, 0, 0};
      s[$urandom_range(0, 2)] = $urandom;
      e[$urandom_range(0, 2)] = $urandom;
    end
    return pack_pair(s[0], s[1], s[2], e[0], e[1], e[2]);
  endfunction

  task automatic load_directed();
    logic [31:0] mx;
    logic [31:0] mn;
    logic [31:0] one;
    mx = 32'h7FFF_FFFF;
    mn = 32'h8000_0000;
    one = 32'h0001_0000;
    vec_pairs_q.push_back(pack_pair(0, 0, 0, 0, 0, 0));            // both zero
    vec_pairs_q.push_back(pack_pair(0, 0, 0, one, 0, 0));          // zero start
    vec_pairs_q.push_back(pack_pair(one, one, 0, 0, 0, 0));        // zero end
    vec_pairs_q.push_back(pack_pair(one, 0, 0, one, 0, 0));        // same direction
    vec_pairs_q.push_back(pack_pair(one, 0, 0, -one, 0, 0));       // opposite
    vec_pairs_q.push_back(pack_pair(one, 0, 0, 0, one, 0));        // quarter turn
    vec_pairs_q.push_back(pack_pair(0, one, 0, 0, 0, one));
    vec_pairs_q.push_back(pack_pair(0, 0, one, one, 0, 0));
    vec_pairs_q.push_back(pack_pair(one, 0, 0, one, one, 0));
    vec_pairs_q.push_back(pack_pair(mx, mx, mx, mx, mx, mx));
    vec_pairs_q.push_back(pack_pair(mn, mn, mn, mx, mx, mx));      // near opposite
    vec_pairs_q.push_back(pack_pair(mn, mn, mn, mn, mn, mn));
    vec_pairs_q.push_back(pack_pair(mx, mn, 0, mn, mx, 0));
    vec_pairs_q.push_back(pack_pair(1, 0, 0, 0, 0, 1));            // one LSB each
    vec_pairs_q.push_back(pack_pair(1, 1, 1, -1, -1, -1));
    vec_pairs_q.push_back(pack_pair(mx, 1, 0, mx, 0, 1));          // tiny angle
    vec_pairs_q.push_back(pack_pair(mn, 0, 0, mx, 0, 0));
    vec_pairs_q.push_back(pack_pair(one, 2*one, 3*one, -3*one, 2*one, -one));
    vec_pairs_q.push_back(pack_pair(mx, 0, 0, mx, 0, -1));
    vec_pairs_q.push_back(pack_pair(0, mn, 0, 0, mx, 1));
  endtask

  // APB write: setup then access; register loads at the access edge
  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (addr[2] == vra_pkg::REG_THR) tol_model = val[9:0];
  endtask

  task automatic drain();
    while (vec_pairs_q.size() != 0 || in_tvalid || rotations_q.size() != 0)
      @(posedge clk);
    repeat (vra_pkg::PIPE_LAT + 20) @(posedge clk);
  endtask

  function automatic int pick_gap();
    int r;
    if ((cycle_cnt / 600) % 3 == 0) return 0;    // stretches with no idling
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // ------------------------------------------------------------- sequence
  initial begin
    logic [9:0] tols[4];
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    tol_model   = vra_pkg::THR_RESET;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // phase at reset value first, then zero, full scale, random, one
    load_directed();
    for (int n = 0; n < 290; n++) vec_pairs_q.push_back(random_pair());
    drain();

    tols = '{10'd0, 10'd1023, 10'($urandom_range(1, 1022)), 10'd1};
    for (int p = 0; p < 4; p++) begin
      // upper bits carry noise, only the low ten are kept
      reg_write({vra_pkg::REG_THR, 2'b00}, {22'($urandom), tols[p]});
      if (p == 1) reg_write(3'd4, $urandom);             // unmapped, ignored
      if (p == 3) load_directed();
      for (int n = 0; n < 240; n++) vec_pairs_q.push_back(random_pair());
      drain();
    end

    $display("Covered %0d items, %0d results over 5 tolerance settings.",
             items_sent, results_seen);
    $display("Case counts: ident %0d, neg %0d, half %0d, general %0d; mismatches %0d",
             code_hist[0], code_hist[1], code_hist[2], code_hist[3], mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // --------------------------------------------------------------- driver
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        rotations_q.push_back(predict_rotation(in_tdata, tol_model));
        items_sent++;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (vec_pairs_q.size() != 0) begin
          in_tdata  <= vec_pairs_q.pop_front();
          in_tvalid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // -------------------------------------------------------------- monitor
  always @(posedge clk) begin
    rotation_t     want;
    vra_pkg::q30_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        code_hist[out_tuser]++;
        if (rotations_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result, code %0d", out_tuser);
        end else begin
          want = rotations_q.pop_front();
          for (int i = 0; i < 9; i++) begin
            got = out_tdata[32*i +: 32];
            if (got !== want.m[i]) begin
              mismatches++;
              if (mismatches <= 10)
                $display("result %0d m%0d%0d: expected %h got %h", results_seen,
                         i / 3, i % 3, want.m[i], got);
            end
          end
          if (out_tuser !== want.code) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d code: expected %0d got %0d", results_seen,
                       want.code, out_tuser);
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        out_gap = pick_gap();
      end
    end
  end

  // ------------------------------------------------------------- watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (vec_pairs_q.size() != 0 || rotations_q.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG);
        $display("RESULT: ERROR");
        $finish;
      end
    end else begin
      idle_cycles <= 0;
    end
  end

  initial begin
    mismatches   = 0;
    items_sent   = 0;
    results_seen = 0;
    code_hist    = '{0, 0, 0, 0};
    cycle_cnt    = 0;
    idle_cycles  = 0;
  end

endmodule

FILE: sim.f
hdl/vra_pkg.sv
hdl/vra_isqrt.sv
hdl/vra_norm3.sv
hdl/vra_matrix.sv
hdl/vector_alignment_rotation_unit.sv
verif/vector_alignment_rotation_unit_tb.sv
